// File: sv/ssd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions of the seven-segment scan driver
package ssd_pkg;

  localparam int unsigned MAX_SCAN = 4;

  localparam logic REQ_NUMBER = 1'b0;
  localparam logic REQ_LETTER = 1'b1;

  localparam logic [13:0] NUM_LIMIT    = 14'd9999;
  localparam logic [13:0] LETTER_LIMIT = 14'd999;
  localparam logic [7:0]  BLANK        = 8'hFF;
  localparam logic [7:0]  DP_LIT_MASK  = 8'h7F;
  localparam logic [4:0]  GLYPH_COUNT  = 5'd18;
  localparam logic [23:0] DWELL_RESET  = 24'd50000;

  localparam logic [7:0] GLYPH_TABLE [18] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90,
    8'hFF, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'h0C
  };

  typedef struct packed {
    logic        req_type;
    logic [13:0] value;
    logic [4:0]  letter_index;
  } req_word_t;

  typedef struct packed {
    logic [3:0]  anodes;
    logic [7:0]  segments;
    logic [23:0] hold_ticks;
    logic [1:0]  digit_position;
    logic        last;
  } scan_word_t;

  typedef logic [MAX_SCAN-1:0][7:0] pat_word_t;

  // count of multiples of unit not above v, v below ten units
  function automatic logic [3:0] dec_digit(input logic [13:0] v, input logic [13:0] unit);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 14'(k) * unit) begin
        d = d + 4'd1;
      end
    end
    return d;
  endfunction

  function automatic logic [7:0] glyph(input logic [4:0] idx);
    logic [7:0] g;
    if (idx < GLYPH_COUNT) begin
      g = GLYPH_TABLE[idx];
    end else begin
      g = BLANK;
    end
    return g;
  endfunction

endpackage

// File: sv/seven_segment_scan_driver.sv
`timescale 1ns / 1ps
// top level of the seven-segment scan driver
// Each request word yields 2*min(DIGIT_COUNT,4) scan words (eight for four digits):
// per digit, rightmost first, a lit word holding dwell_count ticks and then a
// blanking word with hold 0; last marks the final blanking word. A request passes a
// five-stage pipeline (saturate, thousands, hundreds, tens/units, glyph lookup) and then
// the scan sequencer, which emits one word per cycle while scan_stall is low. Requests
// are taken while earlier ones are still in flight. dwell_count resets to 50000.
module seven_segment_scan_driver #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                dwell_we,
  input  logic [23:0]         dwell_wdata,
  input  logic                req_valid,
  output logic                req_stall,
  input  ssd_pkg::req_word_t  req,
  output logic                scan_valid,
  input  logic                scan_stall,
  output ssd_pkg::scan_word_t scan
);

  localparam int unsigned SCAN_LEN = (DIGIT_COUNT > ssd_pkg::MAX_SCAN) ? ssd_pkg::MAX_SCAN :
                                     (DIGIT_COUNT < 1) ? 1 : DIGIT_COUNT;

  logic [23:0]        dwell_count;
  logic               pat_valid;
  logic               pat_stall;
  ssd_pkg::pat_word_t pat;

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_count <= ssd_pkg::DWELL_RESET;
    end else if (dwell_we) begin
      dwell_count <= dwell_wdata;
    end
  end

  ssd_split u_split (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .pat_valid (pat_valid),
    .pat_stall (pat_stall),
    .pat       (pat)
  );

  ssd_scan #(
    .SCAN_LEN (SCAN_LEN)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .dwell_count (dwell_count),
    .pat_valid   (pat_valid),
    .pat_stall   (pat_stall),
    .pat         (pat),
    .scan_valid  (scan_valid),
    .scan_stall  (scan_stall),
    .scan        (scan)
  );

`ifndef ASSERT_OFF
  a_last_blank: assert property (@(posedge clk) disable iff (rst)
    scan_valid && scan.last |-> scan.segments == ssd_pkg::BLANK && scan.hold_ticks == 24'd0)
    else $error("last word not a blanking word");

  a_one_anode: assert property (@(posedge clk) disable iff (rst)
    scan_valid |-> $countones(~scan.anodes) == 1)
    else $error("anode enable not one-cold");

  a_scan_continues: assert property (@(posedge clk) disable iff (rst)
    scan_valid && !scan_stall && !scan.last |=> scan_valid)
    else $error("scan broken before last word");
`endif

endmodule

// File: sv/ssd_split.sv
`timescale 1ns / 1ps
// five-stage pipeline: saturation, decimal digit split and glyph lookup
module ssd_split (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  ssd_pkg::req_word_t req,
  output logic               pat_valid,
  input  logic               pat_stall,
  output ssd_pkg::pat_word_t pat
);

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  logic        t1, t2, t3, t4;
  logic [4:0]  l1, l2, l3, l4;
  logic [13:0] n1;
  logic [9:0]  r2;
  logic [6:0]  r3;
  logic [3:0]  d3_2, d3_3, d3_4, d2_3, d2_4, d1_4, d0_4;
  ssd_pkg::pat_word_t p5;

  logic [13:0] sat_next;
  logic [3:0]  d3_next, d2_next, d1_next;
  logic [3:0]  d0_next;
  logic [9:0]  r2_next;
  logic [6:0]  r3_next;
  ssd_pkg::pat_word_t p5_next;

  assign en5 = !v5 || !pat_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req_stall = !en1;
  assign pat_valid = v5;
  assign pat       = p5;

  always_comb begin
    if (req.req_type == ssd_pkg::REQ_LETTER) begin
      sat_next = (req.value > ssd_pkg::LETTER_LIMIT) ? ssd_pkg::LETTER_LIMIT : req.value;
    end else begin
      sat_next = (req.value > ssd_pkg::NUM_LIMIT) ? ssd_pkg::NUM_LIMIT : req.value;
    end
  end

  always_comb begin
    d3_next = ssd_pkg::dec_digit(n1, 14'd1000);
    r2_next = 10'(n1 - 14'(d3_next) * 14'd1000);
    d2_next = ssd_pkg::dec_digit(14'(r2), 14'd100);
    r3_next = 7'(14'(r2) - 14'(d2_next) * 14'd100);
    d1_next = ssd_pkg::dec_digit(14'(r3), 14'd10);
    d0_next = 4'(r3 - 7'(d1_next) * 7'd10);
  end

  always_comb begin
    p5_next[0] = ssd_pkg::glyph(5'(d0_4));
    p5_next[1] = ssd_pkg::glyph(5'(d1_4));
    p5_next[2] = ssd_pkg::glyph(5'(d2_4));
    if (t4 == ssd_pkg::REQ_LETTER) begin
      p5_next[3] = ssd_pkg::glyph(l4) & ssd_pkg::DP_LIT_MASK;
    end else begin
      p5_next[3] = ssd_pkg::glyph(5'(d3_4));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      t1 <= req.req_type;
      l1 <= req.letter_index;
      n1 <= sat_next;
    end
    if (en2) begin
      t2   <= t1;
      l2   <= l1;
      d3_2 <= d3_next;
      r2   <= r2_next;
    end
    if (en3) begin
      t3   <= t2;
      l3   <= l2;
      d3_3 <= d3_2;
      d2_3 <= d2_next;
      r3   <= r3_next;
    end
    if (en4) begin
      t4   <= t3;
      l4   <= l3;
      d3_4 <= d3_3;
      d2_4 <= d2_3;
      d1_4 <= d1_next;
      d0_4 <= d0_next;
    end
    if (en5) begin
      p5 <= p5_next;
    end
  end

endmodule

// File: sv/ssd_scan.sv
`timescale 1ns / 1ps
// scan sequencer: one lit and one blanking word per digit, rightmost first
module ssd_scan #(
  parameter int unsigned SCAN_LEN = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [23:0]        dwell_count,
  input  logic               pat_valid,
  output logic               pat_stall,
  input  ssd_pkg::pat_word_t pat,
  output logic               scan_valid,
  input  logic               scan_stall,
  output ssd_pkg::scan_word_t scan
);

  localparam int unsigned STEP_W = (2 * SCAN_LEN > 1) ? $clog2(2 * SCAN_LEN) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * SCAN_LEN - 1);

  logic               item_valid;
  ssd_pkg::pat_word_t item_pat;
  logic [STEP_W-1:0]  step;
  logic               out_valid;
  ssd_pkg::scan_word_t out_word;
  ssd_pkg::scan_word_t word_next;

  logic       out_load;
  logic       adv;
  logic       last_step;
  logic       take;
  logic [1:0] pos;

  assign out_load  = !out_valid || !scan_stall;
  assign adv       = out_load && item_valid;
  assign last_step = (step == LAST_STEP);
  assign take      = !item_valid || (adv && last_step);
  assign pat_stall = !take;
  assign pos       = 2'(step >> 1);

  always_comb begin
    word_next.anodes         = ~(4'b0001 << pos);
    word_next.digit_position = pos;
    if (!step[0]) begin
      word_next.segments   = item_pat[pos];
      word_next.hold_ticks = dwell_count;
      word_next.last       = 1'b0;
    end else begin
      word_next.segments   = ssd_pkg::BLANK;
      word_next.hold_ticks = '0;
      word_next.last       = last_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      step       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) out_valid <= item_valid;
      if (adv) begin
        step <= last_step ? '0 : step + STEP_W'(1);
      end
      if (take) item_valid <= pat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_word <= word_next;
    if (take && pat_valid) item_pat <= pat;
  end

  assign scan_valid = out_valid;
  assign scan       = out_word;

endmodule
